FILE: sv/assert_macros.svh
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SKOL_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// Next-cycle implication, disabled during reset.
`define SKOL_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`endif

FILE: sv/skol_pkg.sv
// Types and constants of the shared key ownership ledger.
`default_nettype none

package skol_pkg;

   // Request codes
   typedef enum logic [2:0] {
      REQ_ACQUIRE        = 3'd0,
      REQ_REPEAT         = 3'd1,
      REQ_RELEASE        = 3'd2,
      REQ_RELEASE_OWNER  = 3'd3,
      REQ_RELEASE_ALL    = 3'd4,
      REQ_RELEASE_EXCEPT = 3'd5,
      REQ_OWNS           = 3'd6
   } skol_req_type;

   // Edge kinds
   localparam logic [1:0] KIND_RELEASE = 2'd0;
   localparam logic [1:0] KIND_PRESS   = 2'd1;
   localparam logic [1:0] KIND_REPEAT  = 2'd2;

   // Result status codes
   localparam logic [1:0] ST_REJECT = 2'd0;
   localparam logic [1:0] ST_EDGE   = 2'd1;
   localparam logic [1:0] ST_QUIET  = 2'd2;
   localparam logic [1:0] ST_DONE   = 2'd3;

   // Field widths
   localparam int REQ_W   = 3;
   localparam int OWNER_W = 4;
   localparam int KEY_W   = 6;
   localparam int KEEP_W  = 16;
   localparam int AOC_W   = 5;
   localparam int HKC_W   = 7;

   // Sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_PAIR,
      S_OWN,
      S_KRD,
      S_KWR,
      S_FLUSH
   } skol_state_type;

endpackage

`default_nettype wire

FILE: sv/skol_row_ram.sv
// Holding matrix memory: one row per key, sync read, per-row valid bits.
`default_nettype none

module skol_row_ram
   import skol_pkg::*;
#(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
)(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data
);

   logic [WIDTH-1:0] row_mem [DEPTH];
   logic [WIDTH-1:0] rd_word_ff;
   logic             rd_valid_ff;
   logic [DEPTH-1:0] valid_ff;

   // Storage array, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         row_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_word_ff <= row_mem[rd_addr];
      end
   end

   // Row valid bits; a row never written reads as empty
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_word_ff : '0;

endmodule

`default_nettype wire

FILE: sv/shared_key_ownership_ledger.sv
// Shared key ownership ledger: top level with request sequencer and owner counts.
//
// Requests: a transfer happens at a rising edge with start high and busy low.
// req_type selects acquire, repeat, release, release owner, release all,
// release all except keep mask, or owns query.
// Results: rsp_valid marks each result for exactly one cycle; rsp_last marks
// the final result of a request. The receiver has no way to stall the block.
// Single pair requests (acquire, repeat, release, owns, unknown) take one
// read-modify-write of the key row; busy is already low when the result
// shows, so a new request can be taken then.
// Bulk releases first sweep the owner slots, then walk every key row with a
// read and a write state each, then give the final result.
// Each freed key gives one release result, ascending; the last one freed
// comes with the final result.
// Reset empties the holding matrix through per-row valid bits and clears all
// counts at once; no clearing pass is needed.
`default_nettype none

module shared_key_ownership_ledger
   import skol_pkg::*;
#(
   parameter int OWNER_SLOTS = 16,
   parameter int KEY_SLOTS   = 64
)(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [REQ_W-1:0]   req_type,
   input  wire logic [OWNER_W-1:0] req_owner_slot,
   input  wire logic [KEY_W-1:0]   req_key_index,
   input  wire logic [KEEP_W-1:0]  req_keep_mask,
   output logic                    rsp_valid,
   output logic                    rsp_event_valid,
   output logic [1:0]              rsp_event_kind,
   output logic [KEY_W-1:0]        rsp_event_key,
   output logic [1:0]              rsp_status,
   output logic                    rsp_owns_flag,
   output logic [AOC_W-1:0]        rsp_active_owner_count,
   output logic [HKC_W-1:0]        rsp_held_key_count,
   output logic                    rsp_last
);

   localparam int OW = $clog2(OWNER_SLOTS);
   localparam int KW = $clog2(KEY_SLOTS);
   localparam int CW = $clog2(KEY_SLOTS + 1);
   localparam int AW = $clog2(OWNER_SLOTS + 1);
   localparam int HW = $clog2(KEY_SLOTS + 1);

   // Control and request registers
   skol_state_type         state_ff, state_in;
   logic [REQ_W-1:0]       op_ff, op_in;
   logic [OW-1:0]          own_idx_ff, own_idx_in;
   logic                   own_ok_ff, own_ok_in;
   logic [KW-1:0]          key_idx_ff, key_idx_in;
   logic                   key_ok_ff, key_ok_in;
   logic [OWNER_SLOTS-1:0] rm_ff, rm_in;
   logic [OW-1:0]          o_ff, o_in;
   logic [KW-1:0]          k_ff, k_in;

   // Ledger state outside the row memory
   logic [OWNER_SLOTS-1:0] active_ff, active_in;
   logic [AW-1:0]          act_total_ff, act_total_in;
   logic [HW-1:0]          held_total_ff, held_total_in;

   // Pending freed key of a bulk walk
   logic                   pend_ff, pend_in;
   logic [KW-1:0]          pend_key_ff, pend_key_in;
   logic [HW-1:0]          pend_held_ff, pend_held_in;

   // Result registers
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_ev_ff, rsp_ev_in;
   logic [1:0]             rsp_kind_ff, rsp_kind_in;
   logic [KEY_W-1:0]       rsp_key_ff, rsp_key_in;
   logic [1:0]             rsp_status_ff, rsp_status_in;
   logic                   rsp_owns_ff, rsp_owns_in;
   logic [AOC_W-1:0]       rsp_aoc_ff, rsp_aoc_in;
   logic [HKC_W-1:0]       rsp_hkc_ff, rsp_hkc_in;
   logic                   rsp_last_ff, rsp_last_in;

   // Per-owner key counts; an owner with a clear active bit counts zero
   logic [CW-1:0]          cnt_mem [OWNER_SLOTS];
   logic [CW-1:0]          cnt_rd_ff;
   logic                   cnt_we;
   logic [CW-1:0]          cnt_wdata;

   // Row memory port
   logic                   row_rd_en;
   logic [KW-1:0]          row_rd_addr;
   logic [OWNER_SLOTS-1:0] row_rd_data;
   logic                   row_wr_en;
   logic [KW-1:0]          row_wr_addr;
   logic [OWNER_SLOTS-1:0] row_wr_data;

   // Decoded request and working values
   logic                   accept;
   logic                   req_bulk;
   logic [6:0]             own7;
   logic [6:0]             key7;
   logic                   pair_ok;
   logic [OWNER_SLOTS-1:0] owner_bit;
   logic                   pair_held;
   logic [CW-1:0]          cnt_cur;
   logic [OWNER_SLOTS-1:0] row_new;
   logic                   o_last;
   logic                   k_last;

   skol_row_ram #(
      .WIDTH(OWNER_SLOTS),
      .DEPTH(KEY_SLOTS)
   ) u_rows (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (row_rd_en),
      .rd_addr (row_rd_addr),
      .rd_data (row_rd_data),
      .wr_en   (row_wr_en),
      .wr_addr (row_wr_addr),
      .wr_data (row_wr_data)
   );

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;
   assign own7   = 7'(req_owner_slot);
   assign key7   = 7'(req_key_index);

   assign req_bulk = (req_type == REQ_RELEASE_OWNER) || (req_type == REQ_RELEASE_ALL) ||
                     (req_type == REQ_RELEASE_EXCEPT);

   assign pair_ok   = own_ok_ff && key_ok_ff;
   assign owner_bit = pair_ok ? ({{(OWNER_SLOTS-1){1'b0}}, 1'b1} << own_idx_ff) : '0;
   assign pair_held = pair_ok && ((row_rd_data & owner_bit) != '0);
   assign cnt_cur   = active_ff[own_idx_ff] ? cnt_rd_ff : '0;
   assign o_last    = (o_ff == OW'(OWNER_SLOTS - 1));
   assign k_last    = (k_ff == KW'(KEY_SLOTS - 1));

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = req_bulk ? S_OWN : S_PAIR;
            end
         end
         S_PAIR:  state_in = S_IDLE;
         S_OWN: begin
            if (o_last) begin
               state_in = S_KRD;
            end
         end
         S_KRD:   state_in = S_KWR;
         S_KWR:   state_in = k_last ? S_FLUSH : S_KRD;
         S_FLUSH: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // Datapath and results
   always_comb begin
      op_in         = op_ff;
      own_idx_in    = own_idx_ff;
      own_ok_in     = own_ok_ff;
      key_idx_in    = key_idx_ff;
      key_ok_in     = key_ok_ff;
      rm_in         = rm_ff;
      o_in          = o_ff;
      k_in          = k_ff;
      active_in     = active_ff;
      act_total_in  = act_total_ff;
      held_total_in = held_total_ff;
      pend_in       = pend_ff;
      pend_key_in   = pend_key_ff;
      pend_held_in  = pend_held_ff;
      rsp_valid_in  = 1'b0;
      rsp_ev_in     = rsp_ev_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_status_in = rsp_status_ff;
      rsp_owns_in   = rsp_owns_ff;
      rsp_aoc_in    = rsp_aoc_ff;
      rsp_hkc_in    = rsp_hkc_ff;
      rsp_last_in   = rsp_last_ff;
      cnt_we        = 1'b0;
      cnt_wdata     = cnt_cur;
      row_rd_en     = 1'b0;
      row_rd_addr   = k_ff;
      row_wr_en     = 1'b0;
      row_wr_addr   = key_idx_ff;
      row_wr_data   = row_rd_data;
      row_new       = row_rd_data & ~rm_ff;

      unique case (state_ff)
         // Capture the request and start the row read of a single pair request
         S_IDLE: begin
            if (accept) begin
               op_in      = req_type;
               own_ok_in  = own7 < 7'(OWNER_SLOTS);
               key_ok_in  = key7 < 7'(KEY_SLOTS);
               own_idx_in = own7[OW-1:0];
               key_idx_in = key7[KW-1:0];
               o_in       = '0;
               pend_in    = 1'b0;
               for (int o = 0; o < OWNER_SLOTS; o++) begin
                  if (req_type == REQ_RELEASE_OWNER) begin
                     rm_in[o] = (own7 < 7'(OWNER_SLOTS)) && (own7 == 7'(o));
                  end else if (req_type == REQ_RELEASE_EXCEPT && o < KEEP_W) begin
                     rm_in[o] = ~req_keep_mask[4'(o)];
                  end else begin
                     rm_in[o] = 1'b1;
                  end
               end
               row_rd_en   = !req_bulk;
               row_rd_addr = key7[KW-1:0];
            end
         end

         // Single pair read-modify-write
         S_PAIR: begin
            rsp_valid_in  = 1'b1;
            rsp_ev_in     = 1'b0;
            rsp_kind_in   = KIND_RELEASE;
            rsp_key_in    = '0;
            rsp_status_in = ST_REJECT;
            rsp_owns_in   = 1'b0;
            rsp_last_in   = 1'b1;
            case (op_ff)
               REQ_ACQUIRE: begin
                  if (pair_ok && !pair_held) begin
                     row_wr_en   = 1'b1;
                     row_wr_data = row_rd_data | owner_bit;
                     cnt_we      = 1'b1;
                     cnt_wdata   = cnt_cur + CW'(1);
                     if (!active_ff[own_idx_ff]) begin
                        active_in[own_idx_ff] = 1'b1;
                        act_total_in          = act_total_ff + AW'(1);
                     end
                     if (row_rd_data == '0) begin
                        held_total_in = held_total_ff + HW'(1);
                        rsp_ev_in     = 1'b1;
                        rsp_kind_in   = KIND_PRESS;
                        rsp_key_in    = KEY_W'(key_idx_ff);
                        rsp_status_in = ST_EDGE;
                     end else begin
                        rsp_status_in = ST_QUIET;
                     end
                  end
               end
               REQ_REPEAT: begin
                  if (pair_held) begin
                     rsp_ev_in     = 1'b1;
                     rsp_kind_in   = KIND_REPEAT;
                     rsp_key_in    = KEY_W'(key_idx_ff);
                     rsp_status_in = ST_EDGE;
                  end
               end
               REQ_RELEASE: begin
                  if (pair_held) begin
                     row_wr_en   = 1'b1;
                     row_wr_data = row_rd_data & ~owner_bit;
                     cnt_we      = 1'b1;
                     cnt_wdata   = cnt_cur - CW'(1);
                     if (cnt_cur == CW'(1)) begin
                        active_in[own_idx_ff] = 1'b0;
                        act_total_in          = act_total_ff - AW'(1);
                     end
                     if ((row_rd_data & ~owner_bit) == '0) begin
                        held_total_in = held_total_ff - HW'(1);
                        rsp_ev_in     = 1'b1;
                        rsp_kind_in   = KIND_RELEASE;
                        rsp_key_in    = KEY_W'(key_idx_ff);
                        rsp_status_in = ST_EDGE;
                     end else begin
                        rsp_status_in = ST_QUIET;
                     end
                  end
               end
               REQ_OWNS: begin
                  rsp_status_in = ST_DONE;
                  rsp_owns_in   = pair_held;
               end
               default: begin
                  rsp_status_in = ST_REJECT;
               end
            endcase
            rsp_aoc_in = AOC_W'(act_total_in);
            rsp_hkc_in = HKC_W'(held_total_in);
         end

         // Owner sweep: drop released owners from the active count
         S_OWN: begin
            if (rm_ff[o_ff] && active_ff[o_ff]) begin
               active_in[o_ff] = 1'b0;
               act_total_in    = act_total_ff - AW'(1);
            end
            if (o_last) begin
               k_in = '0;
            end else begin
               o_in = o_ff + OW'(1);
            end
         end

         // Key walk, read half
         S_KRD: begin
            row_rd_en   = 1'b1;
            row_rd_addr = k_ff;
         end

         // Key walk, write half; a freed key pushes out the previous one
         S_KWR: begin
            if ((row_rd_data & rm_ff) != '0) begin
               row_wr_en   = 1'b1;
               row_wr_addr = k_ff;
               row_wr_data = row_new;
               if (row_new == '0) begin
                  held_total_in = held_total_ff - HW'(1);
                  if (pend_ff) begin
                     rsp_valid_in  = 1'b1;
                     rsp_ev_in     = 1'b1;
                     rsp_kind_in   = KIND_RELEASE;
                     rsp_key_in    = KEY_W'(pend_key_ff);
                     rsp_status_in = ST_DONE;
                     rsp_owns_in   = 1'b0;
                     rsp_aoc_in    = AOC_W'(act_total_ff);
                     rsp_hkc_in    = HKC_W'(pend_held_ff);
                     rsp_last_in   = 1'b0;
                  end
                  pend_in      = 1'b1;
                  pend_key_in  = k_ff;
                  pend_held_in = held_total_in;
               end
            end
            if (!k_last) begin
               k_in = k_ff + KW'(1);
            end
         end

         // Final result of a bulk request
         S_FLUSH: begin
            rsp_valid_in  = 1'b1;
            rsp_ev_in     = pend_ff;
            rsp_kind_in   = KIND_RELEASE;
            rsp_key_in    = pend_ff ? KEY_W'(pend_key_ff) : '0;
            rsp_status_in = ST_DONE;
            rsp_owns_in   = 1'b0;
            rsp_aoc_in    = AOC_W'(act_total_ff);
            rsp_hkc_in    = pend_ff ? HKC_W'(pend_held_ff) : HKC_W'(held_total_ff);
            rsp_last_in   = 1'b1;
            pend_in       = 1'b0;
         end

         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   // Owner count memory
   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[own_idx_ff] <= cnt_wdata;
      end
      if (accept) begin
         cnt_rd_ff <= cnt_mem[own_idx_in];
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         active_ff     <= '0;
         act_total_ff  <= '0;
         held_total_ff <= '0;
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         active_ff     <= active_in;
         act_total_ff  <= act_total_in;
         held_total_ff <= held_total_in;
         pend_ff       <= pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      own_idx_ff    <= own_idx_in;
      own_ok_ff     <= own_ok_in;
      key_idx_ff    <= key_idx_in;
      key_ok_ff     <= key_ok_in;
      rm_ff         <= rm_in;
      o_ff          <= o_in;
      k_ff          <= k_in;
      pend_key_ff   <= pend_key_in;
      pend_held_ff  <= pend_held_in;
      rsp_ev_ff     <= rsp_ev_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_status_ff <= rsp_status_in;
      rsp_owns_ff   <= rsp_owns_in;
      rsp_aoc_ff    <= rsp_aoc_in;
      rsp_hkc_ff    <= rsp_hkc_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_event_valid        = rsp_ev_ff;
   assign rsp_event_kind         = rsp_kind_ff;
   assign rsp_event_key          = rsp_key_ff;
   assign rsp_status             = rsp_status_ff;
   assign rsp_owns_flag          = rsp_owns_ff;
   assign rsp_active_owner_count = rsp_aoc_ff;
   assign rsp_held_key_count     = rsp_hkc_ff;
   assign rsp_last               = rsp_last_ff;

endmodule

`default_nettype wire

FILE: sv/skol_checker.sv
// Port-level checker for the ledger, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module skol_checker
   import skol_pkg::*;
(
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             start,
   input wire logic             busy,
   input wire logic             rsp_valid,
   input wire logic             rsp_event_valid,
   input wire logic [1:0]       rsp_event_kind,
   input wire logic [KEY_W-1:0] rsp_event_key,
   input wire logic [1:0]       rsp_status,
   input wire logic             rsp_owns_flag,
   input wire logic             rsp_last
);

   // More results of the same request pending: block must stay busy
   `SKOL_ASSERT_IMP(a_more_keeps_busy, clock, reset, rsp_valid && !rsp_last, busy)

   // A request transfer always occupies the block in the next cycle
   `SKOL_ASSERT_NXT(a_accept_busy, clock, reset, start && !busy, busy)

   // An edge comes only with an edge status or from a bulk walk
   `SKOL_ASSERT_IMP(a_edge_status, clock, reset, rsp_valid && rsp_event_valid, (rsp_status == ST_EDGE) || (rsp_status == ST_DONE))

   // No edge: kind and key read as zero
   `SKOL_ASSERT_IMP(a_quiet_fields, clock, reset, rsp_valid && !rsp_event_valid, (rsp_event_kind == KIND_RELEASE) && (rsp_event_key == '0))

   // A positive owns answer is a finished query without an edge
   `SKOL_ASSERT_IMP(a_owns_query, clock, reset, rsp_valid && rsp_owns_flag, (rsp_status == ST_DONE) && !rsp_event_valid && rsp_last)

endmodule

bind shared_key_ownership_ledger skol_checker u_skol_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_event_valid (rsp_event_valid),
   .rsp_event_kind  (rsp_event_kind),
   .rsp_event_key   (rsp_event_key),
   .rsp_status      (rsp_status),
   .rsp_owns_flag   (rsp_owns_flag),
   .rsp_last        (rsp_last)
);

`default_nettype wire
